// ===== sv/pid_controller_clamped_macros.svh =====
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Concurrent assertion helpers; ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_CLAMPED_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_MACROS_SVH

`ifndef ASSERT_OFF
`define PIDC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define PIDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PIDC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define PIDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== sv/pidc_pkg.sv =====
// ----------------------------------------------------------------------------
// PID controller package
// Register indexes, field widths and the types shared by the PID modules.
// ----------------------------------------------------------------------------
package pidc_pkg;

   localparam int GAIN_FRAC_BITS_DEF = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 23;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;
   localparam int ACC_W = 42;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_KP               = 3'd0,
      REG_KI               = 3'd1,
      REG_KD               = 3'd2,
      REG_INTEGRAL_LIMIT   = 3'd3,
      REG_DERIVATIVE_LIMIT = 3'd4,
      REG_OUTPUT_LIMIT     = 3'd5,
      REG_ERROR_LIMIT      = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic signed [15:0] kp;
      logic signed [15:0] ki;
      logic signed [15:0] kd;
      logic [22:0]        integral_limit;
      logic [16:0]        derivative_limit;
      logic [14:0]        output_limit;
      logic [15:0]        error_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [16:0] err;
      logic signed [23:0] isum;
      logic signed [17:0] deriv;
   } terms_type;

endpackage

// ===== sv/pidc_terms.sv =====
// ----------------------------------------------------------------------------
// PID error, integral and derivative terms
// Clamped error, clamped running integral and clamped error difference,
// with the loop state updated when a transaction moves on.
// ----------------------------------------------------------------------------
module pidc_terms
   import pidc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic signed [15:0] setpoint,
   input  logic signed [15:0] measured,
   input  logic               advance,
   output terms_type          terms
);

   logic signed [23:0] integral_ff;
   logic signed [16:0] prev_err_ff;

   logic signed [16:0] diff;
   logic signed [16:0] elim;
   logic signed [16:0] err;
   logic signed [24:0] isum_raw;
   logic signed [24:0] ilim;
   logic signed [24:0] isum;
   logic signed [17:0] d_raw;
   logic signed [17:0] dlim;
   logic signed [17:0] deriv;

   always_comb begin
      diff = {setpoint[15], setpoint} - {measured[15], measured};
      elim = $signed({1'b0, cfg.error_limit});
      if (diff > elim) begin
         err = elim;
      end else if (diff < -elim) begin
         err = -elim;
      end else begin
         err = diff;
      end

      isum_raw = {integral_ff[23], integral_ff} + 25'(err);
      ilim = $signed({2'b00, cfg.integral_limit});
      if (isum_raw > ilim) begin
         isum = ilim;
      end else if (isum_raw < -ilim) begin
         isum = -ilim;
      end else begin
         isum = isum_raw;
      end

      d_raw = {err[16], err} - {prev_err_ff[16], prev_err_ff};
      dlim = $signed({1'b0, cfg.derivative_limit});
      if (d_raw > dlim) begin
         deriv = dlim;
      end else if (d_raw < -dlim) begin
         deriv = -dlim;
      end else begin
         deriv = d_raw;
      end

      terms.err   = err;
      terms.isum  = isum[23:0];
      terms.deriv = deriv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff <= '0;
         prev_err_ff <= '0;
      end else if (advance) begin
         integral_ff <= isum[23:0];
         prev_err_ff <= err;
      end
   end

endmodule

// ===== sv/pidc_output.sv =====
// ----------------------------------------------------------------------------
// PID output mixer
// Registered gain products, then sum, floor shift and output saturation.
// ----------------------------------------------------------------------------
module pidc_output
   import pidc_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  cfg_type            cfg,
   input  terms_type          terms,
   input  logic               load,
   output logic signed [15:0] drive,
   output logic               saturated
);

   logic signed [16:0] err;
   logic signed [23:0] isum;
   logic signed [17:0] deriv;
   logic signed [15:0] kp;
   logic signed [15:0] ki;
   logic signed [15:0] kd;

   logic signed [32:0] p_kp_in, p_kp_ff;
   logic signed [39:0] p_ki_in, p_ki_ff;
   logic signed [33:0] p_kd_in, p_kd_ff;

   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W-1:0] y;
   logic signed [ACC_W-1:0] olim;

   always_comb begin
      err   = terms.err;
      isum  = terms.isum;
      deriv = terms.deriv;
      kp    = cfg.kp;
      ki    = cfg.ki;
      kd    = cfg.kd;
      p_kp_in = 33'(kp) * 33'(err);
      p_ki_in = 40'(ki) * 40'(isum);
      p_kd_in = 34'(kd) * 34'(deriv);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         p_kp_ff <= p_kp_in;
         p_ki_ff <= p_ki_in;
         p_kd_ff <= p_kd_in;
      end
   end

   always_comb begin
      acc  = ACC_W'(p_kp_ff) + ACC_W'(p_ki_ff) + ACC_W'(p_kd_ff);
      y    = acc >>> GAIN_FRAC_BITS;
      olim = $signed({{(ACC_W-15){1'b0}}, cfg.output_limit});
      if (y > olim) begin
         drive     = olim[15:0];
         saturated = 1'b1;
      end else if (y < -olim) begin
         drive     = -olim[15:0];
         saturated = 1'b1;
      end else begin
         drive     = y[15:0];
         saturated = 1'b0;
      end
   end

endmodule

// ===== sv/pid_controller_clamped.sv =====
// ----------------------------------------------------------------------------
// Clamped positional PID controller
// Request stream: setpoint and measured value. Response stream: the
// saturated drive with a saturation flag, one response per request.
// Gains and limits are to be written on the csr port while the block is idle
// (not enforced by the block); writes take effect on the next transaction.
// Pipeline: input register, term register (error, integral, derivative),
// product register, response register. One transaction per cycle is
// sustained while the response side is ready; the integral and last-error
// state close their loop within the term stage.
// Each stage holds its transaction until the next stage can take it, so a
// stalled response only blocks the upstream stages once they are all full.
// Synchronous reset empties the pipeline, clears the integral and the last
// error, and returns gains to zero and limits to their maximum.
// ----------------------------------------------------------------------------
`include "pid_controller_clamped_macros.svh"

module pid_controller_clamped
   import pidc_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // setpoint[15:0], measured[31:16]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // drive[15:0]
   output logic                  rsp_tuser    // saturated[0]
);

   cfg_type cfg_ff;

   logic               in_vld_ff, term_vld_ff, prod_vld_ff, rsp_vld_ff;
   logic               in_rdy, term_rdy, prod_rdy, rsp_rdy;
   logic signed [15:0] sp_ff, ms_ff;
   terms_type          terms_in, terms_ff;
   logic signed [15:0] drive_in;
   logic               sat_in;
   logic [15:0]        rsp_tdata_ff;
   logic               rsp_tuser_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp               <= '0;
         cfg_ff.ki               <= '0;
         cfg_ff.kd               <= '0;
         cfg_ff.integral_limit   <= '1;
         cfg_ff.derivative_limit <= '1;
         cfg_ff.output_limit     <= '1;
         cfg_ff.error_limit      <= '1;
      end else if (csr_wen) begin
         case (csr_addr)
            REG_KP:               cfg_ff.kp               <= csr_wdata[15:0];
            REG_KI:               cfg_ff.ki               <= csr_wdata[15:0];
            REG_KD:               cfg_ff.kd               <= csr_wdata[15:0];
            REG_INTEGRAL_LIMIT:   cfg_ff.integral_limit   <= csr_wdata[22:0];
            REG_DERIVATIVE_LIMIT: cfg_ff.derivative_limit <= csr_wdata[16:0];
            REG_OUTPUT_LIMIT:     cfg_ff.output_limit     <= csr_wdata[14:0];
            REG_ERROR_LIMIT:      cfg_ff.error_limit      <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_rdy  = !rsp_vld_ff || rsp_tready;
   assign prod_rdy = !prod_vld_ff || rsp_rdy;
   assign term_rdy = !term_vld_ff || prod_rdy;
   assign in_rdy   = !in_vld_ff || term_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         term_vld_ff <= 1'b0;
         prod_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (in_rdy) begin
            in_vld_ff <= req_tvalid;
         end
         if (term_rdy) begin
            term_vld_ff <= in_vld_ff;
         end
         if (prod_rdy) begin
            prod_vld_ff <= term_vld_ff;
         end
         if (rsp_rdy) begin
            rsp_vld_ff <= prod_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && in_rdy) begin
         sp_ff <= req_tdata[15:0];
         ms_ff <= req_tdata[31:16];
      end
      if (in_vld_ff && term_rdy) begin
         terms_ff <= terms_in;
      end
      if (prod_vld_ff && rsp_rdy) begin
         rsp_tdata_ff <= drive_in;
         rsp_tuser_ff <= sat_in;
      end
   end

   pidc_terms u_terms (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .setpoint (sp_ff),
      .measured (ms_ff),
      .advance  (in_vld_ff && term_rdy),
      .terms    (terms_in)
   );

   pidc_output #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_output (
      .clock     (clock),
      .cfg       (cfg_ff),
      .terms     (terms_ff),
      .load      (term_vld_ff && prod_rdy),
      .drive     (drive_in),
      .saturated (sat_in)
   );

   assign req_tready = in_rdy;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   `PIDC_ASSERT_IMPLIES(a_sat_at_limit, clock, reset,
      rsp_tvalid && rsp_tuser,
      rsp_tdata == {1'b0, cfg_ff.output_limit} ||
      rsp_tdata == -{1'b0, cfg_ff.output_limit},
      "saturated response not at the output limit")
   `PIDC_ASSERT_IMPLIES(a_integral_bound, clock, reset,
      term_vld_ff,
      terms_ff.isum <= $signed({1'b0, cfg_ff.integral_limit}) &&
      terms_ff.isum >= -$signed({1'b0, cfg_ff.integral_limit}),
      "integral term beyond its limit")
   `PIDC_ASSERT_IMPLIES(a_ready_only_when_full, clock, reset,
      !req_tready,
      in_vld_ff && term_vld_ff && prod_vld_ff && rsp_vld_ff,
      "request stalled with an empty stage")
   `PIDC_ASSERT_NEXT(a_term_held, clock, reset,
      term_vld_ff && !prod_rdy,
      term_vld_ff,
      "stalled term stage lost its transaction")

endmodule

// ===== dv/pid_controller_clamped_test.sv =====
// ----------------------------------------------------------------------------
// Clamped PID controller testbench
// Drives setpoint/measured transactions with random gaps and back-pressure,
// reloads gains and limits between phases, and compares every response with
// a cycle-free prediction of the clamped error, integral, derivative and
// saturated drive.
// ----------------------------------------------------------------------------
module pid_controller_clamped_test;
   import pidc_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] REG_SPARE = 3'd7;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_PCT = 26;

   typedef struct {
      logic signed [15:0] drive;
      logic               saturated;
   } drive_expect_type;

   class drive_predictor;
      cfg_type            regs;
      logic signed [23:0] integral_sum;
      logic signed [16:0] last_error;
      drive_expect_type   expected_drive[$];
      int                 failures;

      function new();
         regs = '{kp: '0, ki: '0, kd: '0, integral_limit: '1,
                  derivative_limit: '1, output_limit: '1, error_limit: '1};
         integral_sum = '0;
         last_error = '0;
         failures = 0;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
         case (addr)
            REG_KP:               regs.kp = data[15:0];
            REG_KI:               regs.ki = data[15:0];
            REG_KD:               regs.kd = data[15:0];
            REG_INTEGRAL_LIMIT:   regs.integral_limit = data[22:0];
            REG_DERIVATIVE_LIMIT: regs.derivative_limit = data[16:0];
            REG_OUTPUT_LIMIT:     regs.output_limit = data[14:0];
            REG_ERROR_LIMIT:      regs.error_limit = data[15:0];
            default: ;
         endcase
      endfunction

      function longint clamp_mag(longint v, longint lim);
         if (v > lim) return lim;
         if (v < -lim) return -lim;
         return v;
      endfunction

      function void accept_sample(logic signed [15:0] sp, logic signed [15:0] ms);
         longint err, isum, deriv, acc, y;
         drive_expect_type r;
         err = clamp_mag(longint'(sp) - longint'(ms), longint'(regs.error_limit));
         isum = clamp_mag(longint'(integral_sum) + err, longint'(regs.integral_limit));
         deriv = clamp_mag(err - longint'(last_error), longint'(regs.derivative_limit));
         acc = longint'(regs.kp) * err + longint'(regs.ki) * isum
               + longint'(regs.kd) * deriv;
         y = acc >>> GAIN_FRAC_BITS_DEF;
         r.saturated = 1'b0;
         if (y > longint'(regs.output_limit)) begin
            y = longint'(regs.output_limit);
            r.saturated = 1'b1;
         end else if (y < -longint'(regs.output_limit)) begin
            y = -longint'(regs.output_limit);
            r.saturated = 1'b1;
         end
         r.drive = y[15:0];
         integral_sum = isum[23:0];
         last_error = err[16:0];
         expected_drive.push_back(r);
      endfunction

      function void compare_drive(logic [15:0] drive, logic saturated);
         drive_expect_type r;
         if (expected_drive.size() == 0) begin
            $error("response with no pending transaction: drive %0d", $signed(drive));
            failures++;
            return;
         end
         r = expected_drive.pop_front();
         if (drive !== r.drive) begin
            $error("drive: expected %0d, got %0d", r.drive, $signed(drive));
            failures++;
         end
         if (saturated !== r.saturated) begin
            $error("saturated: expected %0b, got %0b", r.saturated, saturated);
            failures++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wen = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // setpoint[15:0], measured[31:16]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // drive[15:0]
   logic                  rsp_tuser;        // saturated[0]

   bit steady_flow = 1'b0;
   bit long_hold_req = 1'b0;
   int cycle_count = 0;

   drive_predictor model = new();

   pid_controller_clamped uut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         model.compare_drive(rsp_tdata, rsp_tuser);
   end

   // response side back-pressure, including one long hold-off
   initial begin : rsp_side
      int hold_left;
      bit hold_used;
      hold_left = 0;
      hold_used = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req && !hold_used) begin
            hold_left = HOLD_CYCLES;
            hold_used = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (steady_flow) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   task automatic send_sample(logic signed [15:0] sp, logic signed [15:0] ms);
      while (!steady_flow && !long_hold_req && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {ms, sp};
      do @(posedge clock); while (!req_tready);
      model.accept_sample(sp, ms);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (model.expected_drive.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      csr_wen <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      model.write_reg(addr, data);
      @(posedge clock);
   endtask

   task automatic load_regs(cfg_type c);
      write_csr(REG_KP, {7'($urandom), c.kp});
      write_csr(REG_KI, {7'($urandom), c.ki});
      write_csr(REG_KD, {7'($urandom), c.kd});
      write_csr(REG_INTEGRAL_LIMIT, c.integral_limit);
      write_csr(REG_DERIVATIVE_LIMIT, {6'($urandom), c.derivative_limit});
      write_csr(REG_OUTPUT_LIMIT, {8'($urandom), c.output_limit});
      write_csr(REG_ERROR_LIMIT, {7'($urandom), c.error_limit});
      write_csr(REG_SPARE, 23'($urandom));
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   function automatic cfg_type make_regs(int kp, int ki, int kd, int il, int dl,
                                         int ol, int el);
      cfg_type c;
      c.kp = kp[15:0];
      c.ki = ki[15:0];
      c.kd = kd[15:0];
      c.integral_limit = il[22:0];
      c.derivative_limit = dl[16:0];
      c.output_limit = ol[14:0];
      c.error_limit = el[15:0];
      return c;
   endfunction

   function automatic logic [31:0] pick_field(int width, bit is_signed);
      int mode;
      logic [31:0] v;
      mode = $urandom_range(0, 9);
      v = $urandom;
      if (mode == 0) return is_signed ? (32'h1 << (width - 1)) : 32'h0;
      if (mode == 1) return is_signed ? ((32'h1 << (width - 1)) - 1) : ((32'h1 << width) - 1);
      if (is_signed && mode < 6) begin
         v = $urandom_range(0, 1023);
         return ($urandom_range(0, 1) != 0) ? -v : v;
      end
      if (!is_signed && mode < 5) return $urandom_range(0, 4095);
      return v & ((32'h1 << width) - 1);
   endfunction

   function automatic cfg_type random_regs();
      cfg_type c;
      c.kp = 16'(pick_field(16, 1'b1));
      c.ki = 16'(pick_field(16, 1'b1));
      c.kd = 16'(pick_field(16, 1'b1));
      c.integral_limit = 23'(pick_field(23, 1'b0));
      c.derivative_limit = 17'(pick_field(17, 1'b0));
      c.output_limit = 15'(pick_field(15, 1'b0));
      c.error_limit = 16'(pick_field(16, 1'b0));
      return c;
   endfunction

   task automatic send_random_sample();
      int kind;
      logic signed [15:0] sp, ms;
      kind = $urandom_range(0, 9);
      sp = 16'($urandom);
      ms = 16'($urandom);
      if (kind == 0) begin
         sp = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
         ms = ($urandom_range(0, 1) != 0) ? -sp - 16'sd1 : 16'sd0;
      end else if (kind < 6) begin
         ms = sp + 16'($urandom_range(0, 128)) - 16'sd64;
      end
      send_sample(sp, ms);
   endtask

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first transaction after reset: derivative against a zero last error
      load_regs(make_regs(0, 0, 256, 8388607, 131071, 32767, 65535));
      send_sample(16'sd100, 16'sd0);
      send_sample(16'sh7FFF, 16'sh8000);
      send_sample(16'sh8000, 16'sh7FFF);
      send_sample(16'sd0, 16'sd0);
      send_sample(-16'sd1, 16'sd0);
      wait_drained();

      // output exactly at and just beyond the limit
      load_regs(make_regs(256, 0, 0, 8388607, 131071, 1000, 65535));
      send_sample(16'sd1000, 16'sd0);
      send_sample(16'sd0, -16'sd1001);
      send_sample(-16'sd1000, 16'sd0);
      send_sample(16'sd0, 16'sd1001);
      send_sample(16'sd0, 16'sd0);
      wait_drained();

      // floor rounding of negative sums
      load_regs(make_regs(1, 0, 0, 8388607, 131071, 32767, 65535));
      send_sample(16'sd0, 16'sd1);
      send_sample(16'sd1, 16'sd0);
      send_sample(16'sd0, 16'sd255);
      wait_drained();

      // all limits zero
      load_regs(make_regs(-32768, -32768, -32768, 0, 0, 0, 0));
      send_sample(16'sh7FFF, 16'sh8000);
      send_sample(16'sh8000, 16'sh7FFF);
      wait_drained();

      // zero output limit with a live error
      load_regs(make_regs(256, 0, 0, 8388607, 131071, 0, 65535));
      send_sample(16'sd5, 16'sd0);
      send_sample(16'sd0, 16'sd0);
      wait_drained();

      // integral, derivative and error clamps
      load_regs(make_regs(0, 256, -32768, 1000, 50, 32767, 300));
      send_sample(16'sh7FFF, 16'sd0);
      send_sample(16'sh7FFF, 16'sd0);
      send_sample(16'sh7FFF, 16'sd0);
      send_sample(16'sh8000, 16'sd0);
      wait_drained();

      for (int phase = 0; phase < 10; phase++) begin
         if (phase == 0)
            load_regs(make_regs(32767, 32767, 32767, 8388607, 131071, 32767, 65535));
         else if (phase == 1)
            load_regs(make_regs(-32768, -32768, -32768, 8388607, 131071, 32767, 65535));
         else
            load_regs(random_regs());
         steady_flow = (phase == 3);
         long_hold_req = (phase == 5);
         for (int n = 0; n < 115; n++)
            send_random_sample();
         wait_drained();
         steady_flow = 1'b0;
      end

      if (model.failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== pid_controller_clamped.f =====
+incdir+sv
sv/pidc_pkg.sv
sv/pidc_terms.sv
sv/pidc_output.sv
sv/pid_controller_clamped.sv
dv/pid_controller_clamped_test.sv
